>>> src/jse_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character tables of the JSON string escaper.
// Used by the front end, the descriptor queue and the back end.
package jse_pkg;

   localparam int JSE_QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LOWA   = 8'h61;
   localparam logic [7:0] UTF8_MARK   = 8'h80;
   localparam logic [7:0] UTF8_TOP4   = 8'hf0;
   localparam logic [7:0] UTF8_TOP3   = 8'he0;

   localparam logic [2:0] KIND_PASS  = 3'd0;
   localparam logic [2:0] KIND_ESC   = 3'd1;
   localparam logic [2:0] KIND_CTL   = 3'd2;
   localparam logic [2:0] KIND_UNI   = 3'd3;
   localparam logic [2:0] KIND_EMPTY = 3'd4;

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] kind;
      logic       open_q;
      logic       close_q;
   } jse_desc_type;

   function automatic logic [2:0] body_len(input logic [2:0] kind);
      logic [2:0] len;
      case (kind)
         KIND_PASS:  len = 3'd1;
         KIND_ESC:   len = 3'd2;
         KIND_CTL:   len = 3'd2;
         KIND_UNI:   len = 3'd6;
         default:    len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'd0, nib};
      end else begin
         c = CHAR_LOWA + {4'd0, nib} - 8'd10;
      end
      return c;
   endfunction

   function automatic logic [7:0] ctl_letter(input logic [7:0] b);
      logic [7:0] c;
      case (b)
         8'd8:    c = 8'h62;
         8'd9:    c = 8'h74;
         8'd10:   c = 8'h6e;
         8'd11:   c = 8'h76;
         8'd12:   c = 8'h66;
         8'd13:   c = 8'h72;
         default: c = 8'h62;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] body_char(input jse_desc_type d, input logic [2:0] j);
      logic [7:0] c;
      case (d.kind)
         KIND_PASS: c = d.data;
         KIND_ESC:  c = (j == 3'd0) ? CHAR_BSLASH : d.data;
         KIND_CTL:  c = (j == 3'd0) ? CHAR_BSLASH : ctl_letter(d.data);
         KIND_UNI: begin
            case (j)
               3'd0:    c = CHAR_BSLASH;
               3'd1:    c = CHAR_U;
               3'd2:    c = CHAR_ZERO;
               3'd3:    c = CHAR_ZERO;
               3'd4:    c = hex_digit(d.data[7:4]);
               default: c = hex_digit(d.data[3:0]);
            endcase
         end
         default:   c = CHAR_QUOTE;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] char_at(input jse_desc_type d, input logic [2:0] idx);
      logic [2:0] j;
      logic [7:0] c;
      j = idx - {2'd0, d.open_q};
      if (d.open_q && idx == 3'd0) begin
         c = CHAR_QUOTE;
      end else if (j < body_len(d.kind)) begin
         c = body_char(d, j);
      end else begin
         c = CHAR_QUOTE;
      end
      return c;
   endfunction

   function automatic logic [2:0] last_index(input jse_desc_type d);
      logic [3:0] total;
      total = {3'd0, d.open_q} + {1'b0, body_len(d.kind)} + {3'd0, d.close_q} - 4'd1;
      return total[2:0];
   endfunction

endpackage

>>> src/jse_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, tracks pending raw UTF-8 bytes and
// classifies each beat into an escape descriptor. Depends on jse_pkg.
module jse_front
   import jse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic [1:0]   req_tuser,
   input  logic         queue_full,
   output logic         push,
   output jse_desc_type push_desc
);

   logic [1:0] raw_ff, raw_in;
   logic [1:0] raw_start;
   logic       first, empty;
   logic [7:0] b;

   assign b          = req_tdata;
   assign first      = req_tuser[0];
   assign empty      = req_tuser[1];
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign raw_start  = first ? 2'd0 : raw_ff;

   always_comb begin
      push_desc.data    = b;
      push_desc.open_q  = first || empty;
      push_desc.close_q = req_tlast || empty;
      push_desc.kind    = KIND_PASS;
      raw_in            = raw_start;
      if (empty) begin
         push_desc.kind = KIND_EMPTY;
         raw_in         = 2'd0;
      end else begin
         if (raw_start != 2'd0) begin
            push_desc.kind = KIND_PASS;
            raw_in         = raw_start - 2'd1;
         end else if (b == CHAR_QUOTE || b == CHAR_BSLASH) begin
            push_desc.kind = KIND_ESC;
         end else if (b >= 8'd8 && b <= 8'd13) begin
            push_desc.kind = KIND_CTL;
         end else if (b >= 8'h20 && b <= 8'h7e) begin
            push_desc.kind = KIND_PASS;
         end else if ((b & UTF8_MARK) == 8'd0) begin
            push_desc.kind = KIND_UNI;
         end else begin
            push_desc.kind = KIND_PASS;
            if ((b & UTF8_TOP4) == UTF8_TOP4) begin
               raw_in = 2'd3;
            end else if ((b & UTF8_TOP4) == UTF8_TOP3) begin
               raw_in = 2'd2;
            end else begin
               raw_in = 2'd1;
            end
         end
         if (req_tlast) begin
            raw_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= 2'd0;
      end else if (push) begin
         raw_ff <= raw_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      push && (req_tlast || empty) |=> raw_ff == 2'd0)
      else $error("raw count not cleared at end of string");

   a_raw_counts_down: assert property (@(posedge clock) disable iff (reset)
      push && !first && !empty && raw_ff != 2'd0 |=> raw_ff < $past(raw_ff))
      else $error("raw count did not count down");

endmodule

>>> src/jse_queue.sv
`timescale 1ns / 1ps
// Descriptor queue between front end and back end.
// Depends on jse_pkg for the descriptor type.
module jse_queue
   import jse_pkg::*;
#(
   parameter int DEPTH = JSE_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  jse_desc_type push_desc,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output jse_desc_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jse_desc_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

>>> src/jse_back.sv
`timescale 1ns / 1ps
// Back end: expands the head descriptor into characters, one beat per
// cycle unless rsp_tready stalls it, through a registered output stage. Depends on jse_pkg.
module jse_back
   import jse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         not_empty,
   input  jse_desc_type head,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic [2:0] idx_ff, idx_in;
   logic       advance, emit, at_end;

   assign advance    = !valid_ff || rsp_tready;
   assign emit       = advance && not_empty;
   assign at_end     = (idx_ff == last_index(head));
   assign pop        = emit && at_end;
   assign valid_in   = advance ? not_empty : valid_ff;
   assign idx_in     = pop ? 3'd0 : (emit ? idx_ff + 3'd1 : idx_ff);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff <= char_at(head, idx_ff);
         last_ff <= at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      not_empty |-> idx_ff <= last_index(head))
      else $error("character index past end of run");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> idx_ff == 3'd0)
      else $error("character index not at start while queue empty");

endmodule

>>> src/json_string_escaper.sv
`timescale 1ns / 1ps
// JSON string escaper. One input beat is one string byte (or an empty-string
// mark); the output is the quoted, escaped text, one character per beat, with
// tlast on the final character caused by each input beat. The front end
// accepts one beat per cycle while the descriptor queue (QUEUE_DEPTH entries)
// has room; the back end emits one character per cycle while it has a
// descriptor and rsp_tready does not stall it, so printable text sustains
// one input beat per cycle, while a beat that expands to k characters (2
// for an escape or an empty string, 6 for a \u00XX form, plus one per quote,
// at most 8) occupies the back end for all k characters. Depends on jse_pkg.
module json_string_escaper
   import jse_pkg::*;
#(
   parameter int QUEUE_DEPTH = JSE_QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // is_last
   input  logic [1:0] req_tuser,   // [0] is_first, [1] empty_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast    // run_last
);

   logic         push, pop, full, not_empty;
   jse_desc_type push_desc, head;

   jse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .queue_full (full),
      .push       (push),
      .push_desc  (push_desc)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sim/json_string_escaper_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for json_string_escaper: directed and random byte strings,
// predicted escaped text compared char by char. Depends on the RTL under src/ only.
module json_string_escaper_test;

   localparam logic [7:0] QUOTE    = 8'h22;
   localparam logic [7:0] BSLASH   = 8'h5c;
   localparam int         IDLE_MAX = 2000;
   localparam int         RAND_PER_PHASE = 112;

   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       empty;
   } text_beat_type;

   typedef struct {
      logic [7:0] ch;
      logic       tail;
   } escaped_char_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic [1:0] req_tuser;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   text_beat_type    text_beats[$];
   escaped_char_type escaped_chars[$];
   logic [1:0]       utf8_pending;
   int               issued;
   int               taken;
   int               send_idle_pct;
   int               recv_stall_pct;
   int               errors;
   int               idle_cycles;
   int               beats_queued;

   json_string_escaper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h61 + {4'd0, nib} - 8'd10;
   endfunction

   function automatic void escape_beat(input logic [7:0] b, input logic first,
                                       input logic last, input logic empty);
      logic [7:0]       chars[$];
      escaped_char_type e;
      if (empty) begin
         utf8_pending = 2'd0;
         chars.push_back(QUOTE);
         chars.push_back(QUOTE);
      end else begin
         if (first) begin
            utf8_pending = 2'd0;
            chars.push_back(QUOTE);
         end
         if (utf8_pending != 2'd0) begin
            chars.push_back(b);
            utf8_pending = utf8_pending - 2'd1;
         end else if (b == QUOTE || b == BSLASH) begin
            chars.push_back(BSLASH);
            chars.push_back(b);
         end else if (b >= 8'd8 && b <= 8'd13) begin
            chars.push_back(BSLASH);
            case (b)
               8'd8:    chars.push_back(8'h62);
               8'd9:    chars.push_back(8'h74);
               8'd10:   chars.push_back(8'h6e);
               8'd11:   chars.push_back(8'h76);
               8'd12:   chars.push_back(8'h66);
               default: chars.push_back(8'h72);
            endcase
         end else if (b >= 8'h20 && b <= 8'h7e) begin
            chars.push_back(b);
         end else if (!b[7]) begin
            chars.push_back(BSLASH);
            chars.push_back(8'h75);
            chars.push_back(8'h30);
            chars.push_back(8'h30);
            chars.push_back(hex_char(b[7:4]));
            chars.push_back(hex_char(b[3:0]));
         end else begin
            chars.push_back(b);
            if (b[7:4] == 4'hf) begin
               utf8_pending = 2'd3;
            end else if (b[7:4] == 4'he) begin
               utf8_pending = 2'd2;
            end else begin
               utf8_pending = 2'd1;
            end
         end
         if (last) begin
            utf8_pending = 2'd0;
            chars.push_back(QUOTE);
         end
      end
      for (int i = 0; i < chars.size(); i++) begin
         e.ch   = chars[i];
         e.tail = (i == chars.size() - 1);
         escaped_chars.push_back(e);
      end
   endfunction

   task automatic push_beat(input logic [7:0] data, input logic first,
                            input logic last, input logic empty);
      text_beat_type t;
      t.data  = data;
      t.first = first;
      t.last  = last;
      t.empty = empty;
      text_beats.push_back(t);
      beats_queued++;
   endtask

   // mostly well-formed strings of mixed units; some broken or noise beats
   task automatic add_string();
      logic [7:0] body[$];
      int         n_units;
      int         pick;
      int         seq_len;
      logic       drop_first;
      logic       drop_last;
      pick = $urandom_range(99);
      if (pick < 6) begin
         push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'b1);
         return;
      end
      if (pick < 9) begin
         push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
         return;
      end
      n_units = $urandom_range(1, 5);
      for (int u = 0; u < n_units; u++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            body.push_back(8'($urandom_range(8'h20, 8'h7e)));
         end else if (pick < 50) begin
            body.push_back($urandom_range(1) ? QUOTE : BSLASH);
         end else if (pick < 60) begin
            body.push_back(8'($urandom_range(8, 13)));
         end else if (pick < 70) begin
            body.push_back($urandom_range(3) == 0 ? 8'h7f : 8'($urandom_range(8'h1f)));
         end else if (pick < 92) begin
            seq_len = $urandom_range(2, 4);
            if (seq_len == 4) begin
               body.push_back({4'hf, 4'($urandom_range(15))});
            end else if (seq_len == 3) begin
               body.push_back({4'he, 4'($urandom_range(15))});
            end else begin
               body.push_back(8'($urandom_range(8'h80, 8'hdf)));
            end
            for (int k = 1; k < seq_len; k++) begin
               if ($urandom_range(99) < 25) begin
                  body.push_back(8'($urandom_range(255)));
               end else begin
                  body.push_back(8'($urandom_range(8'h80, 8'hbf)));
               end
            end
         end else begin
            body.push_back(8'($urandom_range(255)));
         end
      end
      drop_first = ($urandom_range(99) < 8);
      drop_last  = ($urandom_range(99) < 8);
      for (int i = 0; i < body.size(); i++) begin
         push_beat(body[i], (i == 0) && !drop_first, (i == body.size() - 1) && !drop_last,
                   1'b0);
      end
   endtask

   // sender: hold the beat until it is taken, then present the next one or idle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && issued != taken)) begin
         if (text_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= text_beats[0].data;
            req_tlast  <= text_beats[0].last;
            req_tuser  <= {text_beats[0].empty, text_beats[0].first};
            req_tvalid <= 1'b1;
            issued     <= issued + 1;
            void'(text_beats.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predict on accepted input beats, check accepted output beats
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            taken <= taken + 1;
            escape_beat(req_tdata, req_tuser[0], req_tlast, req_tuser[1]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (escaped_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected char %h tlast %b", $time, rsp_tdata, rsp_tlast);
            end else begin
               if (rsp_tdata !== escaped_chars[0].ch) begin
                  errors++;
                  $display("%0t: out_char expected %h got %h", $time,
                           escaped_chars[0].ch, rsp_tdata);
               end
               if (rsp_tlast !== escaped_chars[0].tail) begin
                  errors++;
                  $display("%0t: run_last expected %b got %b", $time,
                           escaped_chars[0].tail, rsp_tlast);
               end
               void'(escaped_chars.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int send_pct[4];
      int recv_pct[4];
      send_pct = '{0, 70, 0, 25};
      recv_pct = '{0, 0, 70, 25};
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      req_tlast      = 1'b0;
      req_tuser      = 2'b00;
      rsp_tready     = 1'b0;
      utf8_pending   = 2'd0;
      issued         = 0;
      taken          = 0;
      errors         = 0;
      idle_cycles    = 0;
      beats_queued   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_beat(8'hff, 1'b1, 1'b1, 1'b1);
      push_beat(8'h00, 1'b0, 1'b0, 1'b1);
      push_beat(8'h61, 1'b1, 1'b1, 1'b0);
      push_beat(QUOTE, 1'b1, 1'b0, 1'b0);
      push_beat(BSLASH, 1'b0, 1'b0, 1'b0);
      for (int c = 8; c <= 13; c++) begin
         push_beat(8'(c), 1'b0, 1'b0, 1'b0);
      end
      push_beat(8'h00, 1'b0, 1'b0, 1'b0);
      push_beat(8'h7f, 1'b0, 1'b0, 1'b0);
      push_beat(8'h7e, 1'b0, 1'b1, 1'b0);
      push_beat(8'hc3, 1'b1, 1'b0, 1'b0);
      push_beat(8'ha9, 1'b0, 1'b0, 1'b0);
      push_beat(8'he2, 1'b0, 1'b0, 1'b0);
      push_beat(8'h82, 1'b0, 1'b0, 1'b0);
      push_beat(8'hac, 1'b0, 1'b0, 1'b0);
      push_beat(8'hf0, 1'b0, 1'b0, 1'b0);
      push_beat(QUOTE, 1'b0, 1'b0, 1'b0);
      push_beat(BSLASH, 1'b0, 1'b0, 1'b0);
      push_beat(8'h0a, 1'b0, 1'b0, 1'b0);
      push_beat(8'h80, 1'b0, 1'b0, 1'b0);
      push_beat(8'hff, 1'b0, 1'b1, 1'b0);
      push_beat(8'he2, 1'b1, 1'b0, 1'b0);
      push_beat(8'h41, 1'b1, 1'b0, 1'b0);
      push_beat(8'h01, 1'b0, 1'b1, 1'b0);
      push_beat(8'hf4, 1'b1, 1'b0, 1'b0);
      push_beat(8'h9f, 1'b0, 1'b1, 1'b0);

      for (int p = 0; p < 4; p++) begin
         while (text_beats.size() != 0 || issued != taken || req_tvalid ||
                escaped_chars.size() != 0) begin
            @(negedge clock);
         end
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         beats_queued   = 0;
         while (beats_queued < RAND_PER_PHASE) begin
            add_string();
         end
      end

      while (text_beats.size() != 0 || issued != taken || req_tvalid ||
             escaped_chars.size() != 0) begin
         @(negedge clock);
      end
      repeat (10) @(posedge clock);
      if (escaped_chars.size() != 0) begin
         errors++;
         $display("%0t: %0d expected chars never arrived", $time, escaped_chars.size());
      end
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
src/jse_pkg.sv
src/jse_front.sv
src/jse_queue.sv
src/jse_back.sv
src/json_string_escaper.sv
sim/json_string_escaper_test.sv
